// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rtcp_bye_pkg.sv =====
// Types and constants of the RTCP BYE packet parser.
package rtcp_bye_pkg;

  localparam logic [7:0] ByeType     = 8'd203;
  localparam logic [1:0] HeaderLast  = 2'd3;

  // parse phase codes
  localparam logic [2:0] PhHeader    = 3'd0;
  localparam logic [2:0] PhSources   = 3'd1;
  localparam logic [2:0] PhReasonLen = 3'd2;
  localparam logic [2:0] PhReason    = 3'd3;
  localparam logic [2:0] PhIgnore    = 3'd4;

  // result kinds
  localparam logic [1:0] KindSource  = 2'd0;
  localparam logic [1:0] KindReason  = 2'd1;
  localparam logic [1:0] KindStatus  = 2'd2;

  // end status error codes
  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrShort     = 2'd1;
  localparam logic [1:0] ErrType      = 2'd2;
  localparam logic [1:0] ErrTruncated = 2'd3;

  // result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] source_id;
    logic [4:0]  source_index;
    logic [7:0]  reason_byte;
    logic [7:0]  reason_length;
    logic [4:0]  source_count;
    logic [1:0]  error_code;
    logic        run_last;
  } result_t;

endpackage

// ===== hdl/rtcp_bye_packet_parser.sv =====
// Streaming RTCP BYE packet parser: byte-wise state update and result queue.
// Results of a byte are written into the result queue as the byte is accepted.
// Throughput: one byte per cycle while the queue has room; each byte yields at
// most two results (final byte's data result plus end status), drained one per
// cycle of out_ready_i by a four-entry queue keeping room for two before a byte.
// Reset (rst_ni low, asynchronous) clears the parse state and empties the queue.
`include "assert_macros.svh"

module rtcp_bye_packet_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        end_of_packet_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] source_id_o,
  output logic [4:0]  source_index_o,
  output logic [7:0]  reason_byte_o,
  output logic [7:0]  reason_length_o,
  output logic [4:0]  source_count_o,
  output logic [1:0]  error_code_o,
  output logic        run_last_o
);

  localparam int unsigned CntW = rtcp_bye_pkg::FifoAw + 1;

  // Parse state
  logic [2:0]  phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic [4:0]  hcount_q, hcount_d;
  logic [4:0]  sdone_q, sdone_d;
  logic [23:0] wshift_q, wshift_d;
  logic [7:0]  rdecl_q, rdecl_d;
  logic [7:0]  rrecv_q, rrecv_d;
  logic [1:0]  err_q, err_d;

  // Results of the byte being accepted
  logic                  in_fire;
  logic                  data_vld;
  rtcp_bye_pkg::result_t data_res;
  rtcp_bye_pkg::result_t end_res;
  logic [1:0]            end_err;
  logic [5:0]            sdone_inc;
  logic [7:0]            rrecv_inc;

  // Result queue
  rtcp_bye_pkg::result_t             fifo_q [rtcp_bye_pkg::FifoDepth];
  logic [rtcp_bye_pkg::FifoAw-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic                              push0, push1, pop;
  rtcp_bye_pkg::result_t             res0, res1;
  rtcp_bye_pkg::result_t             head;

  assign in_fire    = in_valid_i && in_ready_o;
  // Take a byte only while the queue has room for the two results it may cause
  assign in_ready_o = (cnt_q <= CntW'(rtcp_bye_pkg::FifoDepth - 2));

  assign sdone_inc = {1'b0, sdone_q} + 6'd1;
  assign rrecv_inc = rrecv_q + 8'd1;

  // Per-byte parse: advance the phase, gather id bytes, count reason bytes
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    hcount_d = hcount_q;
    sdone_d  = sdone_q;
    wshift_d = wshift_q;
    rdecl_d  = rdecl_q;
    rrecv_d  = rrecv_q;
    err_d    = err_q;
    data_vld = 1'b0;
    data_res = '0;

    case (phase_q)
      rtcp_bye_pkg::PhHeader: begin
        if (pos_q == 2'd0) begin
          hcount_d = byte_in_i[4:0];
        end else if (pos_q == 2'd1 && byte_in_i != rtcp_bye_pkg::ByeType) begin
          err_d = rtcp_bye_pkg::ErrType;
        end
        if (pos_q == rtcp_bye_pkg::HeaderLast) begin
          pos_d = 2'd0;
          if (err_d != rtcp_bye_pkg::ErrNone) begin
            phase_d = rtcp_bye_pkg::PhIgnore;
          end else if (hcount_d != 5'd0) begin
            phase_d = rtcp_bye_pkg::PhSources;
          end else begin
            phase_d = rtcp_bye_pkg::PhReasonLen;
          end
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
      rtcp_bye_pkg::PhSources: begin
        if (pos_q == 2'd3) begin
          // Complete the id and emit it with its list position
          data_vld              = 1'b1;
          data_res.kind         = rtcp_bye_pkg::KindSource;
          data_res.source_id    = {wshift_q, byte_in_i};
          data_res.source_index = sdone_q;
          wshift_d = '0;
          pos_d    = 2'd0;
          if (sdone_inc >= {1'b0, hcount_q}) begin
            phase_d = rtcp_bye_pkg::PhReasonLen;
          end
          sdone_d = sdone_inc[4:0];
        end else begin
          wshift_d = {wshift_q[15:0], byte_in_i};
          pos_d    = pos_q + 2'd1;
        end
      end
      rtcp_bye_pkg::PhReasonLen: begin
        rdecl_d = byte_in_i;
        phase_d = (byte_in_i != 8'd0) ? rtcp_bye_pkg::PhReason : rtcp_bye_pkg::PhIgnore;
      end
      rtcp_bye_pkg::PhReason: begin
        data_vld             = 1'b1;
        data_res.kind        = rtcp_bye_pkg::KindReason;
        data_res.reason_byte = byte_in_i;
        rrecv_d = rrecv_inc;
        if (rrecv_inc >= rdecl_q) begin
          phase_d = rtcp_bye_pkg::PhIgnore;
        end
      end
      default: begin
        // trailing bytes: drop
      end
    endcase
  end

  // End status, taken from the state this byte leaves behind
  always_comb begin
    if (phase_d == rtcp_bye_pkg::PhHeader) begin
      end_err = rtcp_bye_pkg::ErrShort;
    end else if (err_d != rtcp_bye_pkg::ErrNone) begin
      end_err = err_d;
    end else if (phase_d == rtcp_bye_pkg::PhSources) begin
      end_err = rtcp_bye_pkg::ErrTruncated;
    end else begin
      end_err = rtcp_bye_pkg::ErrNone;
    end
    end_res               = '0;
    end_res.kind          = rtcp_bye_pkg::KindStatus;
    end_res.reason_length = (end_err == rtcp_bye_pkg::ErrNone) ? rrecv_d : 8'd0;
    end_res.source_count  = hcount_d;
    end_res.error_code    = end_err;
    end_res.run_last      = 1'b1;
  end

  // Order the results: data first, end status behind it
  always_comb begin
    push0 = in_fire && (data_vld || end_of_packet_i);
    push1 = in_fire && data_vld && end_of_packet_i;
    res0  = data_vld ? data_res : end_res;
    res0.run_last = !(data_vld && end_of_packet_i);
    res1  = end_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rtcp_bye_pkg::PhHeader;
      pos_q    <= '0;
      hcount_q <= '0;
      sdone_q  <= '0;
      wshift_q <= '0;
      rdecl_q  <= '0;
      rrecv_q  <= '0;
      err_q    <= rtcp_bye_pkg::ErrNone;
    end else if (in_fire) begin
      if (end_of_packet_i) begin
        // Packet done: return to the header phase for the next one
        phase_q  <= rtcp_bye_pkg::PhHeader;
        pos_q    <= '0;
        hcount_q <= '0;
        sdone_q  <= '0;
        wshift_q <= '0;
        rdecl_q  <= '0;
        rrecv_q  <= '0;
        err_q    <= rtcp_bye_pkg::ErrNone;
      end else begin
        phase_q  <= phase_d;
        pos_q    <= pos_d;
        hcount_q <= hcount_d;
        sdone_q  <= sdone_d;
        wshift_q <= wshift_d;
        rdecl_q  <= rdecl_d;
        rrecv_q  <= rrecv_d;
        err_q    <= err_d;
      end
    end
  end

  // Result queue: up to two writes and one read per cycle
  assign pop  = out_valid_o && out_ready_i;
  assign wp_d = wp_q + rtcp_bye_pkg::FifoAw'(push0) + rtcp_bye_pkg::FifoAw'(push1);
  assign rp_d = rp_q + rtcp_bye_pkg::FifoAw'(pop);
  assign cnt_d = cnt_q + CntW'(push0) + CntW'(push1) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wp_q] <= res0;
    end
    if (push1) begin
      fifo_q[wp_q + rtcp_bye_pkg::FifoAw'(1)] <= res1;
    end
  end

  assign head            = fifo_q[rp_q];
  assign out_valid_o     = (cnt_q != '0);
  assign kind_o          = head.kind;
  assign source_id_o     = head.source_id;
  assign source_index_o  = head.source_index;
  assign reason_byte_o   = head.reason_byte;
  assign reason_length_o = head.reason_length;
  assign source_count_o  = head.source_count;
  assign error_code_o    = head.error_code;
  assign run_last_o      = head.run_last;

  `ASSERT_AT(a_fifo_bound, cnt_q <= CntW'(rtcp_bye_pkg::FifoDepth), "result queue overflow")
  `ASSERT_IMPLIES(a_sources_nonzero, phase_q == rtcp_bye_pkg::PhSources, hcount_q != 5'd0, "source phase with zero count")
  `ASSERT_IMPLIES(a_pos_phase, pos_q != 2'd0, phase_q == rtcp_bye_pkg::PhHeader || phase_q == rtcp_bye_pkg::PhSources, "byte position outside word phases")
  `ASSERT_NEXT(a_eop_restart, in_fire && end_of_packet_i, phase_q == rtcp_bye_pkg::PhHeader && pos_q == 2'd0 && err_q == rtcp_bye_pkg::ErrNone, "parser not back in header phase after end of packet")

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the streaming RTCP BYE packet parser.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rtcp_bye_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eop;
    bit         hold;   // wait for every due result before offering this byte
  } bye_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // stimulus side
  logic       byte_valid = 1'b0;
  logic [7:0] byte_data = 8'd0;
  logic       byte_eop = 1'b0;
  logic       result_ready = 1'b0;

  // block outputs
  logic        byte_ready;
  logic        result_valid;
  logic [1:0]  kind;
  logic [31:0] source_id;
  logic [4:0]  source_index;
  logic [7:0]  reason_byte;
  logic [7:0]  reason_length;
  logic [4:0]  source_count;
  logic [1:0]  error_code;
  logic        run_last;

  // bytes still to be offered, and results the parser owes us
  bye_byte_t   bytes_to_send[$];
  result_t     bye_results_due[$];
  logic [7:0]  pkt_bytes[$];

  int bytes_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int calm_from = 1 << 30;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_started = 1'b0;

  // predicted parse state
  logic [2:0]  ph = PhHeader;
  logic [1:0]  pos = 2'd0;
  logic [4:0]  hdr_count = 5'd0;
  logic [4:0]  ids_done = 5'd0;
  logic [23:0] id_shift = 24'd0;
  logic [7:0]  reason_declared = 8'd0;
  logic [7:0]  reason_got = 8'd0;
  logic [1:0]  err_held = ErrNone;

  bye_byte_t next_item;
  logic      next_valid;
  logic      next_ready;
  result_t   got;
  result_t   want;

  // Idle on either side only outside calm stretches and the final part of the run.
  wire idling_allowed = (bytes_accepted < calm_from) && ((bytes_accepted / 40) % 3 != 2);

  always #5 clk_i = ~clk_i;

  rtcp_bye_packet_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (byte_valid),
    .in_ready_o     (byte_ready),
    .byte_in_i      (byte_data),
    .end_of_packet_i(byte_eop),
    .out_valid_o    (result_valid),
    .out_ready_i    (result_ready),
    .kind_o         (kind),
    .source_id_o    (source_id),
    .source_index_o (source_index),
    .reason_byte_o  (reason_byte),
    .reason_length_o(reason_length),
    .source_count_o (source_count),
    .error_code_o   (error_code),
    .run_last_o     (run_last)
  );

  function automatic result_t bye_result(logic [1:0] k, logic [31:0] sid, logic [4:0] sidx,
                                         logic [7:0] rbyte, logic [7:0] rlen,
                                         logic [4:0] scount, logic [1:0] err);
    result_t r;
    r.kind          = k;
    r.source_id     = sid;
    r.source_index  = sidx;
    r.reason_byte   = rbyte;
    r.reason_length = rlen;
    r.source_count  = scount;
    r.error_code    = err;
    r.run_last      = 1'b0;
    return r;
  endfunction

  task automatic clear_parse_state();
    ph              = PhHeader;
    pos             = 2'd0;
    hdr_count       = 5'd0;
    ids_done        = 5'd0;
    id_shift        = 24'd0;
    reason_declared = 8'd0;
    reason_got      = 8'd0;
    err_held        = ErrNone;
  endtask

  // Advance the predicted parse by one accepted byte and queue what it yields.
  task automatic parse_bye_byte(input logic [7:0] b, input logic eop);
    result_t    res[2];
    int         n;
    int         i;
    logic [1:0] err;
    n = 0;
    case (ph)
      PhHeader: begin
        // byte 0 carries the count, byte 1 the packet type; the rest is not checked
        if (pos == 2'd0) hdr_count = b[4:0];
        else if (pos == 2'd1 && b != ByeType) err_held = ErrType;
        if (pos == HeaderLast) begin
          pos = 2'd0;
          if (err_held != ErrNone) ph = PhIgnore;
          else if (hdr_count != 5'd0) ph = PhSources;
          else ph = PhReasonLen;
        end else begin
          pos = pos + 2'd1;
        end
      end
      PhSources: begin
        if (pos == HeaderLast) begin
          res[n] = bye_result(KindSource, {id_shift, b}, ids_done, 8'd0, 8'd0, 5'd0, ErrNone);
          n++;
          id_shift = 24'd0;
          pos = 2'd0;
          if (int'(ids_done) + 1 >= int'(hdr_count)) ph = PhReasonLen;
          ids_done = ids_done + 5'd1;
        end else begin
          id_shift = {id_shift[15:0], b};
          pos = pos + 2'd1;
        end
      end
      PhReasonLen: begin
        reason_declared = b;
        ph = (b != 8'd0) ? PhReason : PhIgnore;
      end
      PhReason: begin
        res[n] = bye_result(KindReason, 32'd0, 5'd0, b, 8'd0, 5'd0, ErrNone);
        n++;
        reason_got = reason_got + 8'd1;
        if (reason_got >= reason_declared) ph = PhIgnore;
      end
      default: ;
    endcase
    if (eop) begin
      // a short packet wins over a wrong type
      if (ph == PhHeader) err = ErrShort;
      else if (err_held != ErrNone) err = err_held;
      else if (ph == PhSources) err = ErrTruncated;
      else err = ErrNone;
      res[n] = bye_result(KindStatus, 32'd0, 5'd0, 8'd0,
                          (err == ErrNone) ? reason_got : 8'd0, hdr_count, err);
      n++;
      clear_parse_state();
    end
    if (n > 0) res[n-1].run_last = 1'b1;
    for (i = 0; i < n; i++) bye_results_due.push_back(res[i]);
  endtask

  // Move the assembled packet into the send queue, flagging its final byte.
  task automatic flush_packet(input bit hold);
    bye_byte_t it;
    int        i;
    for (i = 0; i < pkt_bytes.size(); i++) begin
      it.data = pkt_bytes[i];
      it.eop  = (i == pkt_bytes.size() - 1);
      it.hold = hold && (i == 0);
      bytes_to_send.push_back(it);
    end
    pkt_bytes.delete();
  endtask

  // Append a BYE packet with random ids, reason text and trailing bytes.
  task automatic build_packet(input logic [7:0] hdr0, input logic [7:0] type_byte,
                              input int ids, input bit has_reason, input logic [7:0] rlen,
                              input int rbytes, input int trailing);
    int i;
    pkt_bytes.push_back(hdr0);
    pkt_bytes.push_back(type_byte);
    pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(8'($urandom));
    for (i = 0; i < ids * 4; i++) pkt_bytes.push_back(8'($urandom));
    if (has_reason) begin
      pkt_bytes.push_back(rlen);
      for (i = 0; i < rbytes; i++) pkt_bytes.push_back(8'($urandom));
    end
    for (i = 0; i < trailing; i++) pkt_bytes.push_back(8'($urandom));
  endtask

  // Driver: present the next byte once the current transaction has gone through.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid <= 1'b0;
      byte_data  <= 8'd0;
      byte_eop   <= 1'b0;
      gap_left   = 0;
      clear_parse_state();
    end else begin
      if (byte_valid && byte_ready) begin
        parse_bye_byte(byte_data, byte_eop);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!byte_valid || byte_ready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (bytes_to_send.size() != 0 &&
                     !(bytes_to_send[0].hold && bye_results_due.size() != 0)) begin
          next_item = bytes_to_send.pop_front();
          byte_data <= next_item.data;
          byte_eop  <= next_item.eop;
          next_valid = 1'b1;
          // keep offering bytes while the receiver is held off
          if (idling_allowed && hold_left == 0 && $urandom_range(0, 4) == 0)
            gap_left = $urandom_range(1, 19);
        end
        byte_valid <= next_valid;
      end
    end
  end

  // Long receiver hold-off, once, so the result queue fills and the input stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left    <= 0;
      hold_started <= 1'b0;
    end else if (!hold_started && bytes_accepted >= 150) begin
      hold_left    <= 200;
      hold_started <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check every result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (result_valid && result_ready) begin
        got = {kind, source_id, source_index, reason_byte, reason_length,
               source_count, error_code, run_last};
        if (bye_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d unexpected: kind=%0d id=%h idx=%0d rb=%h rl=%0d sc=%0d err=%0d last=%0d",
                     results_seen, got.kind, got.source_id, got.source_index, got.reason_byte,
                     got.reason_length, got.source_count, got.error_code, got.run_last);
        end else begin
          want = bye_results_due.pop_front();
          if (got.kind !== want.kind || got.source_id !== want.source_id ||
              got.source_index !== want.source_index || got.reason_byte !== want.reason_byte ||
              got.reason_length !== want.reason_length ||
              got.source_count !== want.source_count || got.error_code !== want.error_code ||
              got.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d expected: kind=%0d id=%h idx=%0d rb=%h rl=%0d sc=%0d err=%0d last=%0d",
                       results_seen, want.kind, want.source_id, want.source_index,
                       want.reason_byte, want.reason_length, want.source_count,
                       want.error_code, want.run_last);
              $display("result %0d actual:   kind=%0d id=%h idx=%0d rb=%h rl=%0d sc=%0d err=%0d last=%0d",
                       results_seen, got.kind, got.source_id, got.source_index, got.reason_byte,
                       got.reason_length, got.source_count, got.error_code, got.run_last);
            end
          end
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if (idling_allowed && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
      end
      result_ready <= next_ready;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int         pkts;
    int         sel;
    int         cnt;
    int         rlen;
    int         cut;
    bit         has_r;
    logic [7:0] hdr0;
    logic [7:0] bad_type;

    // single byte: too short, count still taken from it
    pkt_bytes = {8'hFF};
    flush_packet(1'b0);
    // wrong type on a packet that also ends inside the header: short wins
    pkt_bytes = {8'h00, 8'h00, 8'hAA};
    flush_packet(1'b0);
    // bare header, no sources and no reason
    pkt_bytes = {8'h80, ByeType, 8'h00, 8'h00};
    flush_packet(1'b0);
    // wrong type with trailing bytes
    pkt_bytes = {8'h81, 8'hCA, 8'h00, 8'h01, 8'h12, 8'h34};
    flush_packet(1'b0);
    // one id at both extremes of the value range is covered by two packets
    pkt_bytes = {8'h81, ByeType, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
    flush_packet(1'b0);
    pkt_bytes = {8'h21, ByeType, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    flush_packet(1'b0);
    // three ids declared, second completed on the final byte: truncated list
    pkt_bytes = {8'h83, ByeType, 8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04,
                 8'hA5, 8'h5A, 8'hC3, 8'h3C};
    flush_packet(1'b0);
    // reason cut short, then full reason with trailing bytes
    pkt_bytes = {8'h80, ByeType, 8'h00, 8'h00, 8'd5, 8'h41, 8'hFF};
    flush_packet(1'b0);
    pkt_bytes = {8'h80, ByeType, 8'h00, 8'h00, 8'd2, 8'h00, 8'h7F, 8'h01, 8'h02};
    flush_packet(1'b1);

    // random part: mostly well-formed packets, some broken ones and noise
    pkts = 0;
    while (bytes_to_send.size() < 480) begin
      sel  = $urandom_range(0, 9);
      cnt  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
      hdr0 = 8'($urandom);
      hdr0[4:0] = 5'(cnt);
      has_r = ($urandom_range(0, 3) != 0);
      rlen  = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      if (sel < 7) begin
        build_packet(hdr0, ByeType, cnt, has_r, 8'(rlen), rlen, $urandom_range(0, 2));
      end else if (sel == 7) begin
        build_packet(hdr0, ByeType, cnt, has_r, 8'(rlen), rlen, 0);
        cut = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
      end else if (sel == 8) begin
        do bad_type = 8'($urandom); while (bad_type == ByeType);
        build_packet(hdr0, bad_type, cnt, has_r, 8'(rlen), rlen, $urandom_range(0, 2));
      end else begin
        cut = $urandom_range(1, 8);
        while (pkt_bytes.size() < cut) pkt_bytes.push_back(8'($urandom));
      end
      flush_packet(pkts == 12);
      pkts++;
    end
    // no idling over the last stretch of bytes
    calm_from = bytes_to_send.size() - 80;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_to_send.size() != 0 || byte_valid) @(negedge clk_i);
    while (bye_results_due.size() != 0) @(negedge clk_i);
    // let any stray result show up
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && bye_results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
